[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file (mau_checker).
// No dependencies; included by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked on every rising clock edge, including reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/core/mau_pkg.sv]
// Package for the modular arithmetic unit: widths, op codes, types.
// No dependencies.
package mau_pkg;
   localparam int MW = 31;
   localparam int EW = 63;
   localparam int RW = 64;
   localparam int OPW = 3;
   localparam logic [MW-1:0] MOD_RESET = 31'd1000000007;

   typedef enum logic [OPW-1:0] {
      OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
      OP_INV = 3'd4, OP_POW = 3'd5, OP_NEG = 3'd6, OP_RED = 3'd7
   } op_type;

   // Shared unit command: rem computes (num % den), 64-bit num.
   typedef struct packed {
      logic          start;
      logic [RW-1:0] num;
      logic [MW-1:0] den;
   } rem_req_type;

   typedef struct packed {
      logic          done;
      logic [RW-1:0] quo;
      logic [MW-1:0] rem;
   } rem_rsp_type;
endpackage

[rtl/core/mau_if.sv]
// Valid/ready channel interfaces for the modular arithmetic unit.
// Depends on mau_pkg.
interface mau_req_if;
   logic                     valid;
   logic                     ready;
   logic [mau_pkg::OPW-1:0]  op;
   logic [mau_pkg::MW-1:0]   lhs;
   logic [mau_pkg::MW-1:0]   rhs;
   logic [mau_pkg::EW-1:0]   exponent;
   logic signed [mau_pkg::RW-1:0] raw_value;
   modport source (output valid, op, lhs, rhs, exponent, raw_value, input ready);
   modport sink (input valid, op, lhs, rhs, exponent, raw_value, output ready);
endinterface

interface mau_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [mau_pkg::MW-1:0] result;
   modport source (output valid, result, input ready);
   modport sink (input valid, result, output ready);
endinterface

[rtl/core/modular_arithmetic_unit_core.sv]
// Modular arithmetic unit: one request in, one residue out, all modulo the
// csr modulus (masked to 31 bits, reset 1000000007). Every operation runs on
// one shared 64-by-31 restoring divider that produces one quotient bit a
// cycle, and every operation first reduces both operands on it. Add, subtract
// and negate need only those reductions, multiply and reduce one more each,
// inverse and divide one divider call per Euclid step (up to ~45 steps), power
// one squaring per exponent bit up to the highest set bit, plus one multiply
// for each set bit. The request side is not ready while an item is in flight;
// the result sits in an output register until the sink takes the transfer.
// Write the modulus only while idle.
// Depends on mau_pkg, mau_if, mau_rem, mau_seq.
module modular_arithmetic_unit_core (
   input  logic                   clock,
   input  logic                   reset,
   mau_req_if.sink                req,
   mau_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [mau_pkg::MW-1:0] csr_wdata
);
   logic [mau_pkg::MW-1:0] mod_ff;
   logic                   busy_ff, busy_in, ovld_ff, ovld_in;
   logic [mau_pkg::MW-1:0] out_ff;
   logic                   seq_done;
   logic [mau_pkg::MW-1:0] seq_res;
   mau_pkg::rem_req_type   rreq;
   mau_pkg::rem_rsp_type   rrsp;
   logic                   take;

   assign req.ready = !busy_ff && !ovld_ff;
   assign take      = req.valid && req.ready;

   mau_rem u_rem (.clock(clock), .reset(reset), .req(rreq), .rsp(rrsp));

   mau_seq u_seq (
      .clock(clock), .reset(reset), .modulus(mod_ff), .start(take),
      .op(req.op), .lhs(req.lhs), .rhs(req.rhs), .exponent(req.exponent),
      .raw_value(req.raw_value), .done(seq_done), .result(seq_res),
      .rreq(rreq), .rrsp(rrsp)
   );

   always_comb begin
      busy_in = busy_ff;
      ovld_in = ovld_ff;
      if (take) busy_in = 1'b1;
      if (seq_done) begin
         busy_in = 1'b0;
         ovld_in = 1'b1;
      end else if (rsp.valid && rsp.ready) begin
         ovld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff  <= mau_pkg::MOD_RESET;
         busy_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else begin
         if (csr_we) mod_ff <= csr_wdata;
         busy_ff <= busy_in;
         ovld_ff <= ovld_in;
      end
      if (seq_done) out_ff <= seq_res;
   end

   assign rsp.valid  = ovld_ff;
   assign rsp.result = out_ff;
endmodule

[rtl/core/mau_rem.sv]
// Restoring divider: 64-bit numerator by 31-bit divisor, one bit per cycle.
// Depends on mau_pkg.
module mau_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  mau_pkg::rem_req_type req,
   output mau_pkg::rem_rsp_type rsp
);
   logic [mau_pkg::RW-1:0] num_ff, num_in;
   logic [mau_pkg::MW:0]   rem_ff, rem_in;
   logic [mau_pkg::MW-1:0] den_ff, den_in;
   logic [6:0]             cnt_ff, cnt_in;
   logic                   busy_ff, busy_in, done_ff, done_in;
   logic [mau_pkg::MW+1:0] trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[mau_pkg::RW-1]} - {2'b0, den_ff};
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         cnt_in  = 7'(mau_pkg::RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[mau_pkg::MW+1]) begin
            rem_in = trial[mau_pkg::MW:0];
            num_in = {num_ff[mau_pkg::RW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[mau_pkg::MW-1:0], num_ff[mau_pkg::RW-1]};
            num_in = {num_ff[mau_pkg::RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = num_ff;
   assign rsp.rem  = rem_ff[mau_pkg::MW-1:0];
endmodule

[rtl/core/mau_seq.sv]
// Sequencer: runs each op as a series of divider calls and narrow steps.
// Depends on mau_pkg (for the rem_req/rem_rsp structs that drive mau_rem).
module mau_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [mau_pkg::MW-1:0] modulus,
   input  logic                  start,
   input  logic [mau_pkg::OPW-1:0] op,
   input  logic [mau_pkg::MW-1:0] lhs,
   input  logic [mau_pkg::MW-1:0] rhs,
   input  logic [mau_pkg::EW-1:0] exponent,
   input  logic [mau_pkg::RW-1:0] raw_value,
   output logic                  done,
   output logic [mau_pkg::MW-1:0] result,
   output mau_pkg::rem_req_type  rreq,
   input  mau_pkg::rem_rsp_type  rrsp
);
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_RA    = 14'b00000000000010,
      S_RB    = 14'b00000000000100,
      S_DISP  = 14'b00000000001000,
      S_MUL   = 14'b00000000010000,
      S_EQ    = 14'b00000000100000,
      S_EU    = 14'b00000001000000,
      S_EMUL  = 14'b00000010000000,
      S_EFIN  = 14'b00000100000000,
      S_PACC  = 14'b00001000000000,
      S_PSQ   = 14'b00010000000000,
      S_RED   = 14'b00100000000000,
      S_WAIT  = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } st_type;

   st_type st_ff, st_in, ret_ff, ret_in;
   logic [mau_pkg::OPW-1:0] op_ff, op_in;
   logic [mau_pkg::MW-1:0]  a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [mau_pkg::EW-1:0]  e_ff, e_in;
   logic [mau_pkg::RW-1:0]  raw_ff, raw_in;
   // Euclid: ea, eb nonneg below 2^31; u, v signed coefficients
   logic [mau_pkg::MW:0]    ea_ff, ea_in, eb_ff, eb_in;
   logic signed [mau_pkg::RW-1:0] u_ff, u_in, v_ff, v_in;
   logic [mau_pkg::RW-1:0]  prod_ff, prod_in;
   logic                    pend_ff, pend_in, done_ff, done_in;
   logic [mau_pkg::RW-1:0]  mag;
   logic [mau_pkg::MW-1:0]  sum;
   logic [mau_pkg::MW:0]    sumw;
   // quotient below 2^31 and |v| at most the modulus: 32-bit signed each
   logic signed [mau_pkg::MW:0]     qv, vn;
   logic signed [2*mau_pkg::MW+1:0] qprod;

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; op_in = op_ff;
      a_in = a_ff; b_in = b_ff; res_in = res_ff; e_in = e_ff; raw_in = raw_ff;
      ea_in = ea_ff; eb_in = eb_ff; u_in = u_ff; v_in = v_ff;
      prod_in = prod_ff; pend_in = 1'b0; done_in = 1'b0;
      rreq.start = 1'b0; rreq.num = '0; rreq.den = modulus;
      mag  = 64'd0 - raw_ff;
      sumw = '0; sum = '0;
      qv   = $signed({1'b0, rrsp.quo[mau_pkg::MW-1:0]});
      vn   = v_ff[mau_pkg::MW:0];
      qprod = qv * vn;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op; e_in = exponent; raw_in = raw_value;
               rreq.start = 1'b1; rreq.num = 64'(lhs);
               b_in = rhs;
               ret_in = S_RA; st_in = S_WAIT;
            end
         end
         S_RA: begin
            a_in = rrsp.rem;
            rreq.start = 1'b1; rreq.num = 64'(b_ff);
            ret_in = S_RB; st_in = S_WAIT;
         end
         S_RB: begin
            b_in = rrsp.rem;
            st_in = S_DISP;
         end
         S_DISP: begin
            st_in = S_DONE;
            if (modulus < 31'd2) begin
               res_in = '0;
            end else begin
               case (mau_pkg::op_type'(op_ff))
                  mau_pkg::OP_ADD: begin
                     sumw = {1'b0, a_ff} + {1'b0, b_ff};
                     res_in = (sumw >= {1'b0, modulus}) ?
                        31'(sumw - {1'b0, modulus}) : 31'(sumw);
                  end
                  mau_pkg::OP_SUB: begin
                     sumw = {1'b0, a_ff} + {1'b0, modulus} - {1'b0, b_ff};
                     res_in = (sumw >= {1'b0, modulus}) ?
                        31'(sumw - {1'b0, modulus}) : 31'(sumw);
                  end
                  mau_pkg::OP_NEG: res_in = (a_ff == '0) ? '0 : modulus - a_ff;
                  mau_pkg::OP_MUL: begin
                     prod_in = 64'(a_ff) * 64'(b_ff);
                     st_in = S_MUL;
                  end
                  mau_pkg::OP_DIV, mau_pkg::OP_INV: begin
                     ea_in = {1'b0, (op_ff == mau_pkg::OP_DIV) ? b_ff : a_ff};
                     eb_in = {1'b0, modulus};
                     u_in = 64'sd1; v_in = 64'sd0;
                     st_in = S_EQ;
                  end
                  mau_pkg::OP_POW: begin
                     res_in = 31'd1;
                     st_in = S_PACC;
                  end
                  default: begin
                     rreq.start = 1'b1;
                     rreq.num = raw_ff[mau_pkg::RW-1] ? mag : raw_ff;
                     ret_in = S_RED; st_in = S_WAIT;
                  end
               endcase
            end
         end
         S_MUL: begin
            rreq.start = 1'b1; rreq.num = prod_ff;
            ret_in = S_EFIN; st_in = S_WAIT;
         end
         S_EQ: begin
            if (eb_ff == '0) begin
               // reduce signed u into range
               rreq.start = 1'b1;
               rreq.num = u_ff[mau_pkg::RW-1] ? 64'(-u_ff) : 64'(u_ff);
               raw_in = 64'(u_ff);
               ret_in = S_RED; st_in = S_WAIT;
            end else begin
               rreq.start = 1'b1; rreq.num = 64'(ea_ff); rreq.den = eb_ff[mau_pkg::MW-1:0];
               ret_in = S_EU; st_in = S_WAIT;
            end
         end
         S_EU: begin
            // quotient is narrow; product registered before use
            prod_in = qprod;
            ea_in = eb_ff; eb_in = {1'b0, rrsp.rem};
            st_in = S_EMUL;
         end
         S_EMUL: begin
            u_in = v_ff; v_in = u_ff - $signed(prod_ff);
            st_in = S_EQ;
         end
         S_RED: begin
            if (raw_ff[mau_pkg::RW-1])
               res_in = (rrsp.rem == '0) ? '0 : modulus - rrsp.rem;
            else
               res_in = rrsp.rem;
            if (op_ff == mau_pkg::OP_DIV) begin
               prod_in = 64'(a_ff) * 64'(res_in);
               st_in = S_MUL;
               op_in = mau_pkg::OP_MUL;
            end else begin
               st_in = S_DONE;
            end
         end
         S_EFIN: begin
            res_in = rrsp.rem;
            st_in = S_DONE;
         end
         S_PACC: begin
            if (e_ff == '0) begin
               st_in = S_DONE;
            end else if (pend_ff) begin
               res_in = rrsp.rem;
               prod_in = 64'(b_ff) * 64'(b_ff);
               st_in = S_PSQ;
            end else if (e_ff[0]) begin
               prod_in = 64'(res_ff) * 64'(a_ff);
               rreq.start = 1'b0;
               st_in = S_PSQ;
               ret_in = S_PACC;
            end else begin
               prod_in = 64'(a_ff) * 64'(a_ff);
               st_in = S_PSQ;
            end
         end
         S_PSQ: begin
            // prod_ff holds the product to reduce; pend marks acc update
            rreq.start = 1'b1; rreq.num = prod_ff;
            if (e_ff[0] && !pend_ff) begin
               ret_in = S_PSQ; pend_in = 1'b1;
            end
            st_in = S_WAIT;
         end
         S_WAIT: begin
            pend_in = pend_ff;
            if (rrsp.done) begin
               if (ret_ff == S_PSQ) begin
                  // accumulator product reduced; now square
                  res_in = rrsp.rem;
                  prod_in = 64'(a_ff) * 64'(a_ff);
                  pend_in = 1'b1;
                  ret_in = S_PACC;
                  st_in = S_PSQ;
               end else if (ret_ff == S_PACC) begin
                  a_in = rrsp.rem;
                  e_in = e_ff >> 1;
                  pend_in = 1'b0;
                  st_in = S_PACC;
               end else begin
                  pend_in = 1'b0;
                  st_in = ret_ff;
               end
            end
         end
         S_DONE: begin
            done_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_PSQ && !(e_ff[0] && !pend_ff)) ret_in = S_PACC;
      if (st_ff == S_PSQ && e_ff[0] && !pend_ff) ret_in = S_PSQ;
      sum = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ret_ff <= S_IDLE; pend_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; pend_ff <= pend_in; done_ff <= done_in;
      end
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; res_ff <= res_in;
      e_ff <= e_in; raw_ff <= raw_in; ea_ff <= ea_in; eb_ff <= eb_in;
      u_ff <= u_in; v_ff <= v_in; prod_ff <= prod_in;
   end

   assign done   = done_ff;
   assign result = res_ff | sum;
endmodule

[rtl/core/mau_checker.sv]
// Port-level checker for the modular arithmetic unit, bound to the top.
// Depends on assert_macros.svh and mau_pkg.
`include "assert_macros.svh"
module mau_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [mau_pkg::MW-1:0] rsp_result
);
   `ASSERT_CLK(a_one_at_a_time, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready after transfer")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result)), "rsp dropped")
   `ASSERT_CLK(a_no_ready_with_rsp, clock, reset, rsp_valid |-> !req_ready, "accept with pending result")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "rsp valid after reset")
endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_result(rsp.result)
);

[verif/modular_arithmetic_unit_core_test.sv]
// Self-checking testbench for modular_arithmetic_unit_core: directed and random requests
// under several moduli, with results checked against an in-bench residue predictor.
// Depends on mau_pkg, mau_if and the RTL of the core.
`timescale 1ns / 1ps

module modular_arithmetic_unit_core_test;

   localparam longint unsigned MOD_MASK = 64'h7FFF_FFFF;

   // Residue scoreboard: holds the modulus copy, predicts each result on the
   // input transfer and compares the result transfers in order.
   class residue_scoreboard_type;
      longint unsigned          modulus;
      logic [mau_pkg::MW-1:0]   residue_q[$];
      int                       fail_count;
      int                       checked_count;

      function new();
         modulus = mau_pkg::MOD_RESET;
         fail_count = 0;
         checked_count = 0;
      endfunction

      function longint unsigned fold_signed(longint unsigned raw, longint unsigned m);
         longint unsigned mag;
         longint unsigned r;
         if (raw[63] == 1'b0) return raw % m;
         mag = -raw;
         r = mag % m;
         return (r == 0) ? 0 : m - r;
      endfunction

      // Extended Euclid on (x, m); the Bezout coefficient is folded into range.
      function longint unsigned euclid_inverse(longint unsigned x, longint unsigned m);
         longint a, b, u, v, q, na, nu;
         a = x;
         b = m;
         u = 1;
         v = 0;
         while (b > 0) begin
            q = a / b;
            na = a - q * b;
            nu = u - q * v;
            a = b;
            b = na;
            u = v;
            v = nu;
         end
         return fold_signed(longint'(u), m);
      endfunction

      function longint unsigned square_multiply(longint unsigned base, longint unsigned e,
                                                longint unsigned m);
         longint unsigned acc, sq;
         acc = 1 % m;
         sq = base;
         while (e > 0) begin
            if (e[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e = e >> 1;
         end
         return acc;
      endfunction

      function void note_request(mau_pkg::op_type op, logic [mau_pkg::MW-1:0] lhs,
                                 logic [mau_pkg::MW-1:0] rhs,
                                 logic [mau_pkg::EW-1:0] exponent,
                                 logic [mau_pkg::RW-1:0] raw_value);
         longint unsigned m, a, b, r;
         m = modulus;
         r = 0;
         if (m >= 2) begin
            a = longint'(lhs) % m;
            b = longint'(rhs) % m;
            case (op)
               mau_pkg::OP_ADD: begin
                  r = a + b;
                  if (r >= m) r -= m;
               end
               mau_pkg::OP_SUB: begin
                  r = a + (m - b);
                  if (r >= m) r -= m;
               end
               mau_pkg::OP_MUL: r = (a * b) % m;
               mau_pkg::OP_DIV: r = (a * euclid_inverse(b, m)) % m;
               mau_pkg::OP_INV: r = euclid_inverse(a, m);
               mau_pkg::OP_POW: r = square_multiply(a, {1'b0, exponent}, m);
               mau_pkg::OP_NEG: r = (a == 0) ? 0 : m - a;
               default: r = fold_signed(raw_value, m);
            endcase
         end
         residue_q.insert(residue_q.size(), r[mau_pkg::MW-1:0]);
      endfunction

      function void check_result(logic [mau_pkg::MW-1:0] result);
         logic [mau_pkg::MW-1:0] want;
         checked_count++;
         if (residue_q.size() == 0) begin
            $error("result transfer with nothing expected: result=%0d", result);
            fail_count++;
            return;
         end
         want = residue_q.pop_front();
         if (result !== want) begin
            $error("field result: expected %0d, actual %0d", want, result);
            fail_count++;
         end
      endfunction

      function int pending();
         return residue_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [mau_pkg::MW-1:0] csr_wdata;
   mau_req_if      req_ch();
   mau_rsp_if      rsp_ch();

   residue_scoreboard_type residue_sb;
   bit sender_gaps;     // sender idles in bursts when set
   bit sink_stalls;     // sink drops ready in bursts when set
   int sent_count;
   int modulus_count;

   modular_arithmetic_unit_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: far beyond the slowest correct run (every item a full
   // 63-bit power with worst stalls on both sides).
   initial begin
      #600_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Sink side: ready in random bursts, stalls off for the final phase.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (sink_stalls && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Result monitor: sampled at the edge, so it sees pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) residue_sb.check_result(rsp_ch.result);
   end

   // One request transfer. valid stays high across back-to-back items, so
   // only one nonblocking write to it lands in any time step.
   task automatic send_request(mau_pkg::op_type op, logic [mau_pkg::MW-1:0] lhs,
                               logic [mau_pkg::MW-1:0] rhs,
                               logic [mau_pkg::EW-1:0] exponent,
                               logic [mau_pkg::RW-1:0] raw_value);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.lhs       <= lhs;
      req_ch.rhs       <= rhs;
      req_ch.exponent  <= exponent;
      req_ch.raw_value <= raw_value;
      do @(posedge clock); while (!req_ch.ready);
      residue_sb.note_request(op, lhs, rhs, exponent, raw_value);
      sent_count++;
   endtask

   // Drop valid and let every outstanding result drain.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (residue_sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Modulus write while idle; the predictor copy is masked like the register.
   task automatic write_modulus(longint unsigned value);
      csr_we    <= 1'b1;
      csr_wdata <= value[mau_pkg::MW-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      residue_sb.modulus = value & MOD_MASK;
      modulus_count++;
      @(posedge clock);
   endtask

   function automatic logic [mau_pkg::MW-1:0] pick_residue(longint unsigned m);
      logic [31:0]     rnd;
      longint unsigned wide;
      // Mostly reduced operands; some span the whole field, unreduced included.
      rnd = $urandom();
      wide = {$urandom(), $urandom()};
      if (m < 2 || $urandom_range(0, 7) == 0) return rnd[mau_pkg::MW-1:0];
      wide = wide % m;
      return wide[mau_pkg::MW-1:0];
   endfunction

   // Random request: mostly short exponents, a few full 63-bit ones.
   task automatic send_random(int count);
      longint unsigned        m;
      logic [mau_pkg::EW-1:0] e;
      logic [mau_pkg::RW-1:0] raw;
      logic [63:0]            rnd64;
      int nbits;
      for (int i = 0; i < count; i++) begin
         m = residue_sb.modulus;
         rnd64 = {$urandom(), $urandom()};
         if ($urandom_range(0, 39) == 0) begin
            e = rnd64[mau_pkg::EW-1:0];
         end else begin
            nbits = $urandom_range(0, 20);
            e = rnd64[mau_pkg::EW-1:0] & ((63'd1 << nbits) - 63'd1);
         end
         raw = {$urandom(), $urandom()};
         send_request(mau_pkg::op_type'($urandom_range(0, 7)), pick_residue(m),
                      pick_residue(m), e, raw);
         // Hold off once mid-run until everything is back.
         if (sent_count == 700) begin
            req_ch.valid <= 1'b0;
            while (residue_sb.pending() > 0) @(posedge clock);
         end
      end
   endtask

   initial begin
      longint unsigned phase_mod[8];
      int phase_items[8];

      phase_mod    = '{13, 2, 2147483647, 1000000, 0, 1, 65537, 1000000007};
      phase_items  = '{270, 240, 270, 270, 40, 40, 270, 260};
      residue_sb   = new();
      sender_gaps  = 1'b1;
      sink_stalls  = 1'b1;
      sent_count   = 0;
      modulus_count = 0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_ch.valid     <= 1'b0;
      req_ch.op        <= mau_pkg::OP_ADD;
      req_ch.lhs       <= '0;
      req_ch.rhs       <= '0;
      req_ch.exponent  <= '0;
      req_ch.raw_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset modulus, field extremes, every op.
      send_request(mau_pkg::OP_ADD, 31'd1000000006, 31'd1000000006, '0, '0);
      send_request(mau_pkg::OP_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '1, '1);  // unreduced
      send_request(mau_pkg::OP_SUB, 31'd0, 31'd1000000006, '0, '0);
      send_request(mau_pkg::OP_SUB, 31'h7FFF_FFFF, 31'd0, '0, '0);
      send_request(mau_pkg::OP_MUL, 31'd1000000006, 31'd1000000006, '0, '0);
      send_request(mau_pkg::OP_MUL, 31'h7FFF_FFFF, 31'h7FFF_FFFE, '0, '0);
      send_request(mau_pkg::OP_DIV, 31'd12345, 31'd0, '0, '0);          // divide by zero
      send_request(mau_pkg::OP_DIV, 31'd1000000006, 31'd2, '0, '0);
      send_request(mau_pkg::OP_INV, 31'd0, '1, '0, '0);                 // inverse of zero
      send_request(mau_pkg::OP_INV, 31'd1, '0, '0, '0);
      send_request(mau_pkg::OP_INV, 31'd1000000006, '0, '0, '0);
      send_request(mau_pkg::OP_POW, 31'd7, '0, '0, '0);                 // zero exponent
      send_request(mau_pkg::OP_POW, 31'd0, '0, '0, '0);
      send_request(mau_pkg::OP_POW, 31'd2, '0, '1, '0);                 // full-width exponent
      send_request(mau_pkg::OP_POW, 31'h7FFF_FFFF, '0, 63'd1000000006, '0);
      send_request(mau_pkg::OP_NEG, 31'd0, '0, '0, '0);
      send_request(mau_pkg::OP_NEG, 31'd1, '0, '0, '0);
      send_request(mau_pkg::OP_RED, '1, '1, '1, 64'h8000_0000_0000_0000); // most negative
      send_request(mau_pkg::OP_RED, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(mau_pkg::OP_RED, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(mau_pkg::OP_RED, '0, '0, '0, 64'd0);
      drain_results();

      // Random phases over a sweep of moduli: tiny, smallest legal, largest,
      // composite (operands not coprime), zero and one, 65537, and back to reset value.
      for (int p = 0; p < 8; p++) begin
         write_modulus(phase_mod[p]);
         if (p == 7) begin
            sender_gaps = 1'b0;
            sink_stalls = 1'b0;
         end
         if (phase_mod[p] == 1000000) begin
            send_request(mau_pkg::OP_INV, 31'd4, '0, '0, '0);
            send_request(mau_pkg::OP_DIV, 31'd3, 31'd10, '0, '0);
         end
         send_random(phase_items[p]);
         drain_results();
      end

      repeat (200) @(posedge clock);
      $display("Checked %0d results from %0d requests over %0d modulus settings.",
               residue_sb.checked_count, sent_count, modulus_count);
      $display("All eight ops covered, incl. zero, unit and non-prime moduli.");
      if (residue_sb.fail_count == 0 && residue_sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (residue_sb.pending() > 0)
            $error("%0d expected results never arrived", residue_sb.pending());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mau_pkg.sv
rtl/core/mau_if.sv
rtl/core/mau_rem.sv
rtl/core/mau_seq.sv
rtl/core/modular_arithmetic_unit_core.sv
rtl/core/mau_checker.sv
verif/modular_arithmetic_unit_core_test.sv
